// File: hw/rtl/pru_pkg.sv
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types, codes and limits of the PNG row unfilter.
// ----------------------------------------------------------------------------
package pru_pkg;

  // default limits of the line store and of the Sub ring
  localparam int ROW_BYTES_MAX_DEF   = 8192;
  localparam int PIXEL_BYTES_MAX_DEF = 8;

  // widths wide enough for the top of each limit's range
  localparam int POS_W  = 16;
  localparam int RIDX_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_BPP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPR = 1'd1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_TAG = 2'd1;
  localparam logic [1:0] ST_SHORT   = 2'd2;

  // row tags
  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_SUB  = 2'd1;
  localparam logic [1:0] TAG_UP   = 2'd2;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       stream_done;
  } out_item_t;

  // one classified item on its way to the back
  typedef struct packed {
    logic              is_data;   // writes the stores
    logic [1:0]        status;
    logic              done;
    logic [7:0]        data_byte;
    logic              sub_hit;   // add the ring byte
    logic              up_hit;    // add the line store byte
    logic [POS_W-1:0]  pos;
    logic [RIDX_W-1:0] ridx;      // ring slot of this byte
    logic [RIDX_W-1:0] sidx;      // ring slot of the left neighbour
  } op_t;

endpackage

// File: hw/rtl/png_row_unfilter.sv
// ----------------------------------------------------------------------------
// png_row_unfilter
// PNG scanline unfilter (None, Sub, Up) over a byte stream of filtered rows.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and gives one result per cycle, sustained while
// out_ready is held high. Each result passes through the queue slot, the
// decode register and the result register. A row tag gives no result
// unless it is unsupported or ends the stream. The pace is set by the line
// store, read as an operation enters the decode stage and written as it
// leaves, with the byte just written forwarded to the next read. The line
// store needs no clearing pass: the first row of each stream never reads
// it. A queue of four operations parts the row parser from the decode
// stage, and a result register parts the decode stage from the output, so
// either side may stall on its own.
module png_row_unfilter import pru_pkg::*; #(
  parameter int ROW_BYTES_MAX   = ROW_BYTES_MAX_DEF,
  parameter int PIXEL_BYTES_MAX = PIXEL_BYTES_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  logic [3:0]  bytes_per_pixel;
  logic [13:0] bytes_per_row;

  logic push;
  logic push_ready;
  op_t  push_op;
  logic pop;
  logic pop_valid;
  op_t  pop_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 4'd1;
      bytes_per_row   <= 14'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BPP: bytes_per_pixel <= cfg_data[3:0];
        REG_BPR: bytes_per_row   <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  pru_front #(
    .ROW_BYTES_MAX   (ROW_BYTES_MAX),
    .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .bpp        (bytes_per_pixel),
    .bpr        (bytes_per_row),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .push       (push),
    .push_ready (push_ready),
    .op         (push_op)
  );

  pru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op)
  );

  pru_back #(
    .ROW_BYTES_MAX   (ROW_BYTES_MAX),
    .PIXEL_BYTES_MAX (PIXEL_BYTES_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (pop_valid),
    .op_pop    (pop),
    .op        (pop_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: hw/rtl/pru_front.sv
// ----------------------------------------------------------------------------
// pru_front
// Row parser: tracks tags, position and stream state, and classifies each
// byte into an operation for the back.
// ----------------------------------------------------------------------------
module pru_front import pru_pkg::*; #(
  parameter int ROW_BYTES_MAX   = ROW_BYTES_MAX_DEF,
  parameter int PIXEL_BYTES_MAX = PIXEL_BYTES_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [3:0]      bpp,
  input  logic [13:0]     bpr,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            push,
  input  logic            push_ready,
  output op_t             op
);

  localparam logic [16:0] RBM_V = 17'(ROW_BYTES_MAX);
  localparam logic [4:0]  PBM_V = 5'(PIXEL_BYTES_MAX);
  localparam logic [RIDX_W-1:0] RIDX_LAST = RIDX_W'(PIXEL_BYTES_MAX - 1);

  logic              awaiting_tag, awaiting_tag_next;
  logic              first_row, first_row_next;
  logic              discarding, discarding_next;
  logic [1:0]        row_filter, row_filter_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [RIDX_W-1:0] ridx, ridx_next;

  logic              accept;
  logic [4:0]        eff_bpp;
  logic [16:0]       eff_bpr;
  logic              row_end;
  logic [4:0]        ridx5;
  logic [4:0]        sidx5;

  assign in_ready = push_ready;
  assign accept   = in_valid & in_ready;

  always_comb begin
    if (bpp == 4'd0) begin
      eff_bpp = 5'd1;
    end else if ({1'b0, bpp} > PBM_V) begin
      eff_bpp = PBM_V;
    end else begin
      eff_bpp = {1'b0, bpp};
    end
    if (bpr == 14'd0) begin
      eff_bpr = 17'd1;
    end else if ({3'b0, bpr} > RBM_V) begin
      eff_bpr = RBM_V;
    end else begin
      eff_bpr = {3'b0, bpr};
    end
  end

  assign row_end = ({1'b0, pos} + 17'd1) >= eff_bpr;
  assign ridx5   = {1'b0, ridx};
  assign sidx5   = (ridx5 >= eff_bpp) ? (ridx5 - eff_bpp) : (ridx5 + PBM_V - eff_bpp);

  always_comb begin
    awaiting_tag_next = awaiting_tag;
    first_row_next    = first_row;
    discarding_next   = discarding;
    row_filter_next   = row_filter;
    pos_next          = pos;
    ridx_next         = ridx;
    push              = 1'b0;
    op                = '0;
    op.data_byte      = in_item.data_byte;
    op.done           = in_item.end_of_stream;
    op.pos            = pos;
    op.ridx           = ridx;
    op.sidx           = sidx5[RIDX_W-1:0];

    if (accept) begin
      if (discarding) begin
        if (in_item.end_of_stream) begin
          discarding_next = 1'b0;
        end
      end else if (awaiting_tag) begin
        if (in_item.data_byte > 8'd2) begin
          push      = 1'b1;
          op.status = ST_BAD_TAG;
          discarding_next = ~in_item.end_of_stream;
        end else begin
          row_filter_next   = in_item.data_byte[1:0];
          awaiting_tag_next = 1'b0;
          pos_next          = '0;
          ridx_next         = '0;
          if (in_item.end_of_stream) begin
            push      = 1'b1;
            op.status = ST_SHORT;
          end
        end
      end else begin
        push       = 1'b1;
        op.is_data = 1'b1;
        op.status  = (in_item.end_of_stream && !row_end) ? ST_SHORT : ST_OK;
        op.sub_hit = (row_filter == TAG_SUB) && ({1'b0, pos} >= {12'b0, eff_bpp});
        op.up_hit  = (row_filter == TAG_UP) && !first_row;
        if (row_end) begin
          awaiting_tag_next = 1'b1;
          first_row_next    = 1'b0;
          pos_next          = '0;
        end else begin
          pos_next  = pos + POS_W'(1);
          ridx_next = (ridx == RIDX_LAST) ? '0 : ridx + RIDX_W'(1);
        end
      end
      // end of stream: restart the stream state
      if (in_item.end_of_stream) begin
        awaiting_tag_next = 1'b1;
        first_row_next    = 1'b1;
        discarding_next   = 1'b0;
        pos_next          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_tag <= 1'b1;
      first_row    <= 1'b1;
      discarding   <= 1'b0;
      row_filter   <= TAG_NONE;
      pos          <= '0;
      ridx         <= '0;
    end else begin
      awaiting_tag <= awaiting_tag_next;
      first_row    <= first_row_next;
      discarding   <= discarding_next;
      row_filter   <= row_filter_next;
      pos          <= pos_next;
      ridx         <= ridx_next;
    end
  end

endmodule

// File: hw/rtl/pru_queue.sv
// ----------------------------------------------------------------------------
// pru_queue
// Short operation queue between the row parser and the decode back.
// ----------------------------------------------------------------------------
module pru_queue import pru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic push_ready,
  input  op_t  push_op,
  input  logic pop,
  output logic pop_valid,
  output op_t  pop_op
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  op_t              slots [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_LAST) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_LAST) ? '0 : rd_ptr + IDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/pru_back.sv
// ----------------------------------------------------------------------------
// pru_back
// Decode back: line store read, Sub/Up add, store write-back and the
// result register.
// ----------------------------------------------------------------------------
module pru_back import pru_pkg::*; #(
  parameter int ROW_BYTES_MAX   = ROW_BYTES_MAX_DEF,
  parameter int PIXEL_BYTES_MAX = PIXEL_BYTES_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_pop,
  input  op_t       op,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int ADDR_W = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
  localparam int RING_W = (PIXEL_BYTES_MAX > 1) ? $clog2(PIXEL_BYTES_MAX) : 1;

  logic [7:0] line_mem [ROW_BYTES_MAX];
  logic [7:0] ring     [PIXEL_BYTES_MAX];

  op_t        s1;
  logic       s1_valid;
  logic [7:0] rd_data;
  logic       fwd_hit;
  logic [7:0] fwd_data;

  logic       s1_adv;
  logic       load;
  logic [7:0] up_byte;
  logic [7:0] addend;
  logic [7:0] decoded;

  assign s1_adv = s1_valid & (~out_valid | out_ready);
  assign load   = op_valid & (~s1_valid | s1_adv);
  assign op_pop = load;

  // the byte written this cycle is not yet visible to the read
  assign up_byte = fwd_hit ? fwd_data : rd_data;

  always_comb begin
    if (s1.sub_hit) begin
      addend = ring[s1.sidx[RING_W-1:0]];
    end else if (s1.up_hit) begin
      addend = up_byte;
    end else begin
      addend = 8'd0;
    end
  end

  assign decoded = s1.data_byte + addend;

  always_ff @(posedge clk) begin
    if (s1_adv && s1.is_data) begin
      line_mem[s1.pos[ADDR_W-1:0]] <= decoded;
    end
    if (load) begin
      rd_data <= line_mem[op.pos[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.is_data) begin
      ring[s1.ridx[RING_W-1:0]] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1       <= op;
      fwd_hit  <= s1_adv && s1.is_data && (s1.pos == op.pos);
      fwd_data <= decoded;
    end
    if (s1_adv) begin
      out_item.out_byte    <= (s1.status == ST_OK) ? decoded : 8'd0;
      out_item.status      <= s1.status;
      out_item.stream_done <= s1.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/pru_checker.sv
// ----------------------------------------------------------------------------
// pru_checker
// Port-level checks of the PNG row unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module pru_checker import pru_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != ST_OK) |-> out_item.out_byte == 8'd0)
    else $error("flagged result carries a byte");

  // a short row is only ever reported by the final transfer
  a_short_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == ST_SHORT) |-> out_item.stream_done)
    else $error("short row reported before end of stream");

endmodule

bind png_row_unfilter pru_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
